### rtl/ika_pkg.sv
// Shared types, constants and step functions for the arm inverse kinematics pipeline.
package ika_pkg;

  // Angle word inside the datapath: Q.16 radians
  localparam int AngW = 20;
  // CORDIC operand width before the x256 scaling
  localparam int CinW = 18;
  localparam int CordicIters = 16;
  // pre-rotation stage plus one stage per iteration
  localparam int CordicLat = CordicIters + 1;

  localparam logic signed [AngW-1:0] HALF_PI = 20'sd102944;

  // round(atan(2^-i) * 65536)
  localparam logic signed [AngW-1:0] ATAN_TAB [CordicIters] = '{
    20'sd51472, 20'sd30386, 20'sd16055, 20'sd8150, 20'sd4091, 20'sd2047,
    20'sd1024,  20'sd512,   20'sd256,   20'sd128,  20'sd64,   20'sd32,
    20'sd16,    20'sd8,     20'sd4,     20'sd2
  };

  // Configuration register indexes
  localparam logic [1:0] CFG_UPPER_LINK = 2'd0;
  localparam logic [1:0] CFG_LOWER_LINK = 2'd1;
  localparam logic [1:0] CFG_SHOULDER_H = 2'd2;

  // One step of the bit-pair square root
  typedef struct packed {
    logic [33:0] rem;
    logic [33:0] res;
  } isq_t;

  // One lane of the restoring ratio divider
  typedef struct packed {
    logic [34:0] rem;
    logic [13:0] q;
    logic [34:0] den;
    logic        sat;
    logic        neg;
  } div_t;

  // Target data carried alongside the arithmetic
  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [16:0] zrel;
    logic [15:0] r;
    logic        oor;
  } side_t;

  // Ratio operands, Q6.24
  typedef struct packed {
    logic [34:0] numa;
    logic [34:0] numc;
    logic [30:0] denc;
  } rop_t;

  function automatic isq_t isq_step(isq_t a, logic [33:0] b);
    isq_t o;
    logic [33:0] trial;
    trial = a.res + b;
    if (a.rem >= trial) begin
      o.rem = a.rem - trial;
      o.res = (a.res >> 1) + b;
    end else begin
      o.rem = a.rem;
      o.res = a.res >> 1;
    end
    return o;
  endfunction

  function automatic div_t div_step(div_t a);
    div_t o;
    logic [34:0] sh;
    o  = a;
    sh = {a.rem[33:0], 1'b0};
    if (sh >= a.den) begin
      o.rem = sh - a.den;
      o.q   = {a.q[12:0], 1'b1};
    end else begin
      o.rem = sh;
      o.q   = {a.q[12:0], 1'b0};
    end
    return o;
  endfunction

  // Signed Q2.14 cosine from a finished divider lane, clamped to [-1, 1]
  function automatic logic signed [15:0] quo_to_t(div_t a);
    logic signed [15:0] mag;
    mag = a.sat ? 16'sd16384 : $signed({2'b00, a.q});
    return a.neg ? -mag : mag;
  endfunction

  // Q.16 to Q3.12 with round half up and saturation
  function automatic logic signed [15:0] to_q12(logic signed [23:0] a);
    logic signed [23:0] v;
    v = (a + 24'sd8) >>> 4;
    if (v > 24'sd32767) return 16'sh7fff;
    if (v < -24'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

endpackage

### rtl/ika_cordic.sv
// Pipelined vectoring CORDIC: atan2(y, x) in Q.16 radians, one pair per cycle.
module ika_cordic (
  input  logic                             clk,
  input  logic signed [ika_pkg::CinW-1:0]  y_in,
  input  logic signed [ika_pkg::CinW-1:0]  x_in,
  output logic signed [ika_pkg::AngW-1:0]  angle
);

  logic signed [29:0]              cx [0:ika_pkg::CordicIters];
  logic signed [29:0]              cy [0:ika_pkg::CordicIters];
  logic signed [ika_pkg::AngW-1:0] cz [0:ika_pkg::CordicIters];
  logic                            zf [0:ika_pkg::CordicIters];
  logic signed [29:0]              xs;
  logic signed [29:0]              ys;

  // operands scaled by 256
  assign xs = {{4{x_in[ika_pkg::CinW-1]}}, x_in, 8'b0};
  assign ys = {{4{y_in[ika_pkg::CinW-1]}}, y_in, 8'b0};

  always_ff @(posedge clk) begin
    // quadrant pre-rotation so that x is not negative
    zf[0] <= (x_in == '0) && (y_in == '0);
    if (xs < 0) begin
      if (ys >= 0) begin
        cx[0] <= ys;
        cy[0] <= -xs;
        cz[0] <= ika_pkg::HALF_PI;
      end else begin
        cx[0] <= -ys;
        cy[0] <= xs;
        cz[0] <= -ika_pkg::HALF_PI;
      end
    end else begin
      cx[0] <= xs;
      cy[0] <= ys;
      cz[0] <= '0;
    end
    // micro-rotations, one per stage
    for (int i = 0; i < ika_pkg::CordicIters; i++) begin
      zf[i+1] <= zf[i];
      if (cy[i] > 0) begin
        cx[i+1] <= cx[i] + (cy[i] >>> i);
        cy[i+1] <= cy[i] - (cx[i] >>> i);
        cz[i+1] <= cz[i] + ika_pkg::ATAN_TAB[i];
      end else begin
        cx[i+1] <= cx[i] - (cy[i] >>> i);
        cy[i+1] <= cy[i] + (cx[i] >>> i);
        cz[i+1] <= cz[i] - ika_pkg::ATAN_TAB[i];
      end
    end
  end

  // atan2 of the origin is zero
  assign angle = zf[ika_pkg::CordicIters] ? '0 : cz[ika_pkg::CordicIters];

endmodule

### rtl/four_joint_arm_inverse_kinematics_unit.sv
// Top level: four-joint arm inverse kinematics, fully pipelined.
//
// A target (target_x, target_y, target_z, signed Q3.12 metres) is taken on
// every clock edge where start is high; busy is always low. The four joint
// angles (signed Q3.12 radians) and out_of_reach appear at the outputs for
// exactly one cycle, marked by done; one result leaves per cycle in input
// order, and the receiver cannot stall. The result passes through a chain of
// pipelined units: products and sums (2 stages), a 17-stage square root of
// the planar and spatial distances, a link-length multiply stage, a divider
// set-up stage, a 14-stage ratio divider, a 16-stage square root for the acos
// sine term (square plus 15 steps), a 17-stage CORDIC, all four angles
// resolved in parallel, and the output register. Targets beyond
// reach or at the shoulder origin give out_of_reach with all angles zero.
// The user must write link lengths and shoulder height (cfg_write, cfg_addr,
// cfg_data) only while the pipeline is empty; the block does not enforce it.
module four_joint_arm_inverse_kinematics_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] target_x,
  input  logic signed [15:0] target_y,
  input  logic signed [15:0] target_z,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_addr,
  input  logic [14:0]        cfg_data,
  output logic               done,
  output logic signed [15:0] base_angle,
  output logic signed [15:0] shoulder_angle,
  output logic signed [15:0] elbow_angle,
  output logic signed [15:0] wrist_angle,
  output logic               out_of_reach
);

  // Stage map
  localparam int StSum      = 2;
  localparam int IsqSteps   = 17;
  localparam int StRoot     = StSum + IsqSteps;
  localparam int StDen      = StRoot + 1;
  localparam int StPre      = StDen + 1;
  localparam int DivSteps   = 14;
  localparam int StQuo      = StPre + DivSteps;
  localparam int StTsq      = StQuo + 1;
  localparam int AsqSteps   = 15;
  localparam int StAcosRoot = StTsq + AsqSteps;
  localparam int StAng      = StAcosRoot + ika_pkg::CordicLat;

  // Configuration registers
  logic [14:0] upper_link_length;
  logic [14:0] lower_link_length;
  logic [14:0] shoulder_height;

  logic               vld    [1:StAng];
  ika_pkg::side_t     side_q [1:StAng];
  ika_pkg::isq_t      rq     [StSum:StRoot];
  ika_pkg::isq_t      dq     [StSum:StRoot];
  ika_pkg::rop_t      rop_q  [StSum:StDen];
  logic [32:0]        dena_q;
  ika_pkg::div_t      dva    [StPre:StQuo];
  ika_pkg::div_t      dvc    [StPre:StQuo];
  ika_pkg::isq_t      aqa    [StTsq:StAcosRoot];
  ika_pkg::isq_t      aqc    [StTsq:StAcosRoot];
  logic signed [15:0] taq    [StTsq:StAcosRoot];
  logic signed [15:0] tcq    [StTsq:StAcosRoot];

  // stage 1 products
  logic [30:0] m_x2;
  logic [30:0] m_y2;
  logic [31:0] m_zr2;
  logic [29:0] m_l1sq;
  logic [29:0] m_l2sq;
  logic [29:0] m_l1l2;
  logic [31:0] m_reach2;

  logic signed [16:0] zrel_c;
  logic signed [31:0] x2_c;
  logic signed [31:0] y2_c;
  logic signed [33:0] zr2_c;
  logic [15:0]        reach_c;
  logic [31:0]        rsq_c;
  logic [32:0]        d2_c;
  logic               oor_c;
  logic [31:0]        ld_c;
  logic [34:0]        maga_c;
  logic [34:0]        magc_c;
  logic signed [15:0] ta_c;
  logic signed [15:0] tc_c;
  logic signed [31:0] tasq_c;
  logic signed [31:0] tcsq_c;
  logic signed [ika_pkg::AngW-1:0] ang_yaw;
  logic signed [ika_pkg::AngW-1:0] ang_elev;
  logic signed [ika_pkg::AngW-1:0] ang_a;
  logic signed [ika_pkg::AngW-1:0] ang_c;
  logic signed [23:0] th1_c;
  logic signed [23:0] th2_c;
  logic signed [23:0] th3_c;
  logic signed [23:0] th4_c;

  assign busy = 1'b0;

  // Front end: height offset and squares
  assign zrel_c  = $signed({target_z[15], target_z}) - $signed({2'b00, shoulder_height});
  assign x2_c    = target_x * target_x;
  assign y2_c    = target_y * target_y;
  assign zr2_c   = zrel_c * zrel_c;
  assign reach_c = {1'b0, upper_link_length} + {1'b0, lower_link_length};

  // Distance sums and reach test
  assign rsq_c = {1'b0, m_x2} + {1'b0, m_y2};
  assign d2_c  = {1'b0, rsq_c} + {1'b0, m_zr2};
  assign oor_c = (d2_c == '0) || (d2_c > {1'b0, m_reach2});

  // L1 * D, doubled when registered into dena_q
  assign ld_c = upper_link_length * dq[StRoot].res[16:0];

  // Ratio magnitudes
  assign maga_c = rop_q[StDen].numa[34] ? -rop_q[StDen].numa : rop_q[StDen].numa;
  assign magc_c = rop_q[StDen].numc[34] ? -rop_q[StDen].numc : rop_q[StDen].numc;

  // Clamped cosines and their squares
  assign ta_c   = ika_pkg::quo_to_t(dva[StQuo]);
  assign tc_c   = ika_pkg::quo_to_t(dvc[StQuo]);
  assign tasq_c = ta_c * ta_c;
  assign tcsq_c = tc_c * tc_c;

  // Control: configuration and valid line
  always_ff @(posedge clk) begin
    if (rst) begin
      upper_link_length <= 15'd3277;
      lower_link_length <= 15'd3359;
      shoulder_height   <= 15'd2691;
      for (int k = 1; k <= StAng; k++) vld[k] <= 1'b0;
      done <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_addr)
          ika_pkg::CFG_UPPER_LINK: upper_link_length <= cfg_data;
          ika_pkg::CFG_LOWER_LINK: lower_link_length <= cfg_data;
          ika_pkg::CFG_SHOULDER_H: shoulder_height   <= cfg_data;
          default: ;
        endcase
      end
      vld[1] <= start && !busy;
      for (int k = 2; k <= StAng; k++) vld[k] <= vld[k-1];
      done <= vld[StAng];
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    // stage 1
    side_q[1] <= '{x: target_x, y: target_y, zrel: zrel_c, r: 16'd0, oor: 1'b0};
    m_x2      <= x2_c[30:0];
    m_y2      <= y2_c[30:0];
    m_zr2     <= zr2_c[31:0];
    m_l1sq    <= upper_link_length * upper_link_length;
    m_l2sq    <= lower_link_length * lower_link_length;
    m_l1l2    <= upper_link_length * lower_link_length;
    m_reach2  <= reach_c * reach_c;

    // stage 2
    side_q[StSum] <= '{x: side_q[1].x, y: side_q[1].y, zrel: side_q[1].zrel,
                       r: side_q[1].r, oor: oor_c};
    rq[StSum]     <= '{rem: {2'b00, rsq_c}, res: 34'd0};
    dq[StSum]     <= '{rem: {1'b0, d2_c}, res: 34'd0};
    rop_q[StSum]  <= '{numa: {5'b0, m_l1sq} + {2'b0, d2_c} - {5'b0, m_l2sq},
                       numc: {5'b0, m_l1sq} + {5'b0, m_l2sq} - {2'b0, d2_c},
                       denc: {m_l1l2, 1'b0}};

    // side line, planar reach joins once its root is done
    for (int k = StSum + 1; k <= StAng; k++) begin
      if (k == StDen) begin
        side_q[k] <= '{x: side_q[k-1].x, y: side_q[k-1].y, zrel: side_q[k-1].zrel,
                       r: rq[StRoot].res[15:0], oor: side_q[k-1].oor};
      end else begin
        side_q[k] <= side_q[k-1];
      end
    end

    // square roots of r^2 and D^2
    for (int k = StSum + 1; k <= StRoot; k++) begin
      rq[k] <= ika_pkg::isq_step(rq[k-1], 34'd1 << (32 - 2 * (k - StSum - 1)));
      dq[k] <= ika_pkg::isq_step(dq[k-1], 34'd1 << (32 - 2 * (k - StSum - 1)));
    end
    for (int k = StSum + 1; k <= StDen; k++) rop_q[k] <= rop_q[k-1];

    // denominator of the shoulder ratio
    dena_q <= {ld_c, 1'b0};

    // divider set-up
    dva[StPre] <= '{rem: maga_c, q: 14'd0, den: {2'b00, dena_q},
                    sat: maga_c >= {2'b00, dena_q}, neg: rop_q[StDen].numa[34]};
    dvc[StPre] <= '{rem: magc_c, q: 14'd0, den: {4'b0000, rop_q[StDen].denc},
                    sat: magc_c >= {4'b0000, rop_q[StDen].denc},
                    neg: rop_q[StDen].numc[34]};

    // divider steps
    for (int k = StPre + 1; k <= StQuo; k++) begin
      dva[k] <= ika_pkg::div_step(dva[k-1]);
      dvc[k] <= ika_pkg::div_step(dvc[k-1]);
    end

    // sine term argument 1 - t^2
    taq[StTsq] <= ta_c;
    tcq[StTsq] <= tc_c;
    aqa[StTsq] <= '{rem: 34'd268435456 - 34'(tasq_c), res: 34'd0};
    aqc[StTsq] <= '{rem: 34'd268435456 - 34'(tcsq_c), res: 34'd0};

    // square roots of the sine terms
    for (int k = StTsq + 1; k <= StAcosRoot; k++) begin
      aqa[k] <= ika_pkg::isq_step(aqa[k-1], 34'd1 << (28 - 2 * (k - StTsq - 1)));
      aqc[k] <= ika_pkg::isq_step(aqc[k-1], 34'd1 << (28 - 2 * (k - StTsq - 1)));
      taq[k] <= taq[k-1];
      tcq[k] <= tcq[k-1];
    end

    // output stage
    out_of_reach <= side_q[StAng].oor;
    if (side_q[StAng].oor) begin
      base_angle     <= '0;
      shoulder_angle <= '0;
      elbow_angle    <= '0;
      wrist_angle    <= '0;
    end else begin
      base_angle     <= ika_pkg::to_q12(th1_c);
      shoulder_angle <= ika_pkg::to_q12(th2_c);
      elbow_angle    <= ika_pkg::to_q12(th3_c);
      wrist_angle    <= ika_pkg::to_q12(th4_c);
    end
  end

  // Four angle units, fed in the same stage
  ika_cordic u_yaw (
    .clk   (clk),
    .y_in  ($signed({{2{side_q[StAcosRoot].y[15]}}, side_q[StAcosRoot].y})),
    .x_in  ($signed({{2{side_q[StAcosRoot].x[15]}}, side_q[StAcosRoot].x})),
    .angle (ang_yaw)
  );

  ika_cordic u_elev (
    .clk   (clk),
    .y_in  ($signed({side_q[StAcosRoot].zrel[16], side_q[StAcosRoot].zrel})),
    .x_in  ($signed({2'b00, side_q[StAcosRoot].r})),
    .angle (ang_elev)
  );

  ika_cordic u_acos_a (
    .clk   (clk),
    .y_in  ($signed({3'b000, aqa[StAcosRoot].res[14:0]})),
    .x_in  ($signed({{2{taq[StAcosRoot][15]}}, taq[StAcosRoot]})),
    .angle (ang_a)
  );

  ika_cordic u_acos_c (
    .clk   (clk),
    .y_in  ($signed({3'b000, aqc[StAcosRoot].res[14:0]})),
    .x_in  ($signed({{2{tcq[StAcosRoot][15]}}, tcq[StAcosRoot]})),
    .angle (ang_c)
  );

  // Joint angles in Q.16
  assign th1_c = 24'(ang_yaw) - 24'(ika_pkg::HALF_PI);
  assign th2_c = 24'(ang_elev) + 24'(ang_a) - 24'(ika_pkg::HALF_PI);
  assign th3_c = 24'(ang_c) - 24'(ika_pkg::HALF_PI);
  assign th4_c = 24'(ika_pkg::HALF_PI) - (th2_c + 24'(ang_c));

endmodule
